@@ sv/bre_pkg.sv @@
// shared constants and types for the bitmap range engine
`default_nettype none

package bre_pkg;

    localparam int MAX_BITS    = 256;
    localparam int CHUNK_W     = 64;
    localparam int NUM_CHUNKS  = MAX_BITS / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int CHUNK_OFS_W = $clog2(CHUNK_W);
    localparam int POS_W       = 8;
    localparam int SIZE_W      = 9;
    localparam int CMD_W       = 4;
    localparam int PCNT_W      = CHUNK_OFS_W + 1;

    localparam logic [SIZE_W-1:0]      SIZE_MAX   = SIZE_W'(MAX_BITS);
    localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(NUM_CHUNKS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_RANGE   = 4'd0,
        CMD_CLR_RANGE   = 4'd1,
        CMD_FLIP_RANGE  = 4'd2,
        CMD_SET_ALL     = 4'd3,
        CMD_CLR_ALL     = 4'd4,
        CMD_FLIP_ALL    = 4'd5,
        CMD_TEST        = 4'd6,
        CMD_COUNT_ALL   = 4'd7,
        CMD_COUNT_RANGE = 4'd8,
        CMD_FIRST_SET   = 4'd9,
        CMD_FIRST_CLR   = 4'd10,
        CMD_LAST_SET    = 4'd11
    } bre_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } bre_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic                   load_item;
        logic                   chunk_en;
        logic [CHUNK_IDX_W-1:0] chunk_idx;
        logic                   load_out;
    } bre_ctl_t;

endpackage

`default_nettype wire

@@ sv/bre_ctrl.sv @@
// sequencer for the bitmap range engine: handshakes and chunk walk
`default_nettype none

module bre_ctrl
    import bre_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output bre_ctl_t  ctl
);

    bre_state_t             state_reg, state_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic                   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                chunk_next = '0;
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == LAST_CHUNK)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl.load_item = 1'b0;
        ctl.chunk_en  = 1'b0;
        ctl.chunk_idx = chunk_reg;
        ctl.load_out  = 1'b0;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                ctl.load_item = in_valid;
            end
            ST_RUN:
                ctl.chunk_en = 1'b1;
            ST_FIN:
                ctl.load_out = !out_valid_reg || !out_stall;
            default:
                in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ sv/bre_datapath.sv @@
// bit store, per-chunk masking, update, popcount and search logic
`default_nettype none

module bre_datapath
    import bre_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIZE_W-1:0] cfg_wr_data,
    input  wire bre_ctl_t          ctl,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [POS_W-1:0]  start_pos,
    input  wire logic [POS_W-1:0]  end_pos,
    output logic                   bit_value,
    output logic [SIZE_W-1:0]      set_count,
    output logic                   found,
    output logic [POS_W-1:0]       position,
    output logic                   is_empty,
    output logic                   all_set
);

    function automatic logic [PCNT_W-1:0] popcount(input logic [CHUNK_W-1:0] v);
        logic [PCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_W; i++)
            n = n + PCNT_W'(v[i]);
        return n;
    endfunction

    logic [CHUNK_W-1:0] store_reg [NUM_CHUNKS];
    logic [SIZE_W-1:0]  bit_count_reg;

    bre_cmd_t           cmd_reg;
    logic [POS_W-1:0]   start_reg;
    logic [POS_W-1:0]   hi_reg;
    logic               range_ok_reg;

    logic               bitv_reg, bitv_next;
    logic [SIZE_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0]  total_reg, total_next;
    logic               fnd_reg, fnd_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [SIZE_W-1:0]  size;
    logic               range_ok;
    logic [SIZE_W-1:0]  hi_full;

    logic [CHUNK_W-1:0] cur;
    logic [CHUNK_W-1:0] new_chunk;
    logic [CHUNK_W-1:0] size_m;
    logic [CHUNK_W-1:0] rng_m;
    logic [CHUNK_W-1:0] from_m;
    logic [CHUNK_W-1:0] op_m;
    logic [CHUNK_W-1:0] cnt_m;
    logic [CHUNK_W-1:0] cand;
    logic [POS_W-1:0]   g;
    logic [CHUNK_OFS_W-1:0] lo_idx;
    logic [CHUNK_OFS_W-1:0] hi_idx;
    logic               test_ok;

    // size in use, oversized register acts as the full store
    assign size = (bit_count_reg > SIZE_MAX) ? SIZE_MAX : bit_count_reg;

    assign range_ok = ({1'b0, start_pos} < size) && (end_pos >= start_pos);
    assign hi_full  = ({1'b0, end_pos} >= size) ? (size - 1'b1) : {1'b0, end_pos};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_count_reg <= SIZE_MAX;
        else if (cfg_wr_en)
            bit_count_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg      <= bre_cmd_t'(cmd);
            start_reg    <= start_pos;
            hi_reg       <= hi_full[POS_W-1:0];
            range_ok_reg <= range_ok;
        end
    end

    // per-chunk masks, update and search
    always_comb
    begin
        cur = store_reg[ctl.chunk_idx];
        for (int i = 0; i < CHUNK_W; i++)
        begin
            g         = {ctl.chunk_idx, CHUNK_OFS_W'(i)};
            size_m[i] = {1'b0, g} < size;
            from_m[i] = size_m[i] && (g >= start_reg);
            rng_m[i]  = from_m[i] && range_ok_reg && (g <= hi_reg);
        end

        op_m  = '0;
        cnt_m = '0;
        cand  = '0;
        case (cmd_reg)
            CMD_SET_RANGE, CMD_CLR_RANGE, CMD_FLIP_RANGE: op_m = rng_m;
            CMD_SET_ALL, CMD_CLR_ALL, CMD_FLIP_ALL:       op_m = size_m;
            CMD_COUNT_ALL:   cnt_m = size_m;
            CMD_COUNT_RANGE: cnt_m = rng_m;
            CMD_FIRST_SET:   cand  = cur & from_m;
            CMD_FIRST_CLR:   cand  = ~cur & from_m;
            CMD_LAST_SET:    cand  = cur & size_m;
            default:         op_m  = '0;
        endcase

        case (cmd_reg)
            CMD_SET_RANGE, CMD_SET_ALL:   new_chunk = cur | op_m;
            CMD_CLR_RANGE, CMD_CLR_ALL:   new_chunk = cur & ~op_m;
            CMD_FLIP_RANGE, CMD_FLIP_ALL: new_chunk = cur ^ op_m;
            default:                      new_chunk = cur;
        endcase

        lo_idx = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
            if (cand[i])
                lo_idx = CHUNK_OFS_W'(i);
        hi_idx = '0;
        for (int i = 0; i < CHUNK_W; i++)
            if (cand[i])
                hi_idx = CHUNK_OFS_W'(i);

        test_ok = ({1'b0, start_reg} < size)
                  && (start_reg[POS_W-1 -: CHUNK_IDX_W] == ctl.chunk_idx);
    end

    // accumulators across the chunk walk
    always_comb
    begin
        bitv_next  = bitv_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        fnd_next   = fnd_reg;
        pos_next   = pos_reg;
        if (ctl.load_item)
        begin
            bitv_next  = 1'b0;
            cnt_next   = '0;
            total_next = '0;
            fnd_next   = 1'b0;
            pos_next   = '0;
        end
        else if (ctl.chunk_en)
        begin
            cnt_next   = cnt_reg + SIZE_W'(popcount(new_chunk & cnt_m));
            total_next = total_reg + SIZE_W'(popcount(new_chunk & size_m));
            if (cmd_reg == CMD_TEST && test_ok)
                bitv_next = cur[start_reg[CHUNK_OFS_W-1:0]];
            if (|cand)
            begin
                if (cmd_reg == CMD_LAST_SET)
                begin
                    fnd_next = 1'b1;
                    pos_next = {ctl.chunk_idx, hi_idx};
                end
                else if (!fnd_reg)
                begin
                    fnd_next = 1'b1;
                    pos_next = {ctl.chunk_idx, lo_idx};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bitv_reg  <= bitv_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
        fnd_reg   <= fnd_next;
        pos_reg   <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHUNKS; i++)
                store_reg[i] <= '0;
        end
        else if (ctl.chunk_en)
            store_reg[ctl.chunk_idx] <= new_chunk;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            bit_value <= bitv_reg;
            set_count <= cnt_reg;
            found     <= fnd_reg;
            position  <= pos_reg;
            is_empty  <= (total_reg == '0);
            all_set   <= (total_reg == size);
        end
    end

endmodule

`default_nettype wire

@@ sv/bitmap_range_engine_unit.sv @@
// top level of the bitmap range engine: sequencer plus datapath
// A 256-bit vector, cleared at reset, with range and whole-vector set, clear and
// flip, a single-bit test, population counts, first-set, first-clear and last-set
// searches. bit_count (reset 256, values above 256 act as 256) sets how many bits
// are in use; bits at or above it are neither changed nor seen, and keep their
// values. Each input word gives exactly one result word, which also reports
// whether the in-use bits are all clear or all set after the command. A word is
// loaded into the result register after a walk over the four 64-bit chunks of
// the store (read, mask, update, write back, popcount and priority encode on one
// chunk per cycle), from the FIN state, which waits while out_stall holds a result.
// The next input word can be taken in the cycle after the result loads, while
// that result may still wait under out_stall, and not before. Write bit_count
// only while no word is in flight.
`default_nettype none

module bitmap_range_engine_unit
    import bre_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [SIZE_W-1:0] cfg_wr_data,
    // input words
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [POS_W-1:0]  start_pos,
    input  wire logic [POS_W-1:0]  end_pos,
    // result words
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   bit_value,
    output logic [SIZE_W-1:0]      set_count,
    output logic                   found,
    output logic [POS_W-1:0]       position,
    output logic                   is_empty,
    output logic                   all_set
);

    bre_ctl_t ctl;

    // sequencer: accept, chunk walk, result hand-off
    bre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // store, per-chunk logic and result register
    bre_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .cmd         (cmd),
        .start_pos   (start_pos),
        .end_pos     (end_pos),
        .bit_value   (bit_value),
        .set_count   (set_count),
        .found       (found),
        .position    (position),
        .is_empty    (is_empty),
        .all_set     (all_set)
    );

    // an accepted word keeps the input closed while it is worked on
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after accepting a word");

    // the store is only written while the input is closed
    a_walk_closed: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.chunk_en |-> in_stall)
        else $error("chunk walk while input open");

    // a nonzero count means some in-use bit is set
    a_count_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && set_count != '0 |-> !is_empty)
        else $error("nonzero count with empty vector");

    // loading a result always presents it
    a_load_presents: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> out_valid)
        else $error("result loaded but not presented");

endmodule

`default_nettype wire
